### rtl/core/pva_pkg.sv
// Shared types and constants for the polyphonic voice allocator core.
// No dependencies; used by pva_cell and the top level.
package pva_pkg;

   localparam int NUM_VOICES_DEFAULT = 16;
   localparam int NOTE_W             = 7;
   localparam int IDX_W              = 4;
   localparam int CNT_W              = 5;
   localparam int CSR_W              = 5;

   localparam logic [CSR_W-1:0] VOICES_IN_USE_RESET = 5'd16;

   typedef enum logic {
      REQ_NOTE_OFF = 1'b0,
      REQ_NOTE_ON  = 1'b1
   } req_kind_type;

   // Event token that walks down the voice chain, one cell per cycle while the chain advances.
   typedef struct packed {
      logic               valid;
      req_kind_type       kind;
      logic [NOTE_W-1:0]  note;
      logic               found;    // a voice has been claimed upstream
      logic [IDX_W-1:0]   chosen;   // low bits of the claimed voice index
      logic [CNT_W-1:0]   count;    // active voices counted so far
   } token_type;

endpackage

### rtl/core/pva_cell.sv
// One voice slot of the allocator chain: note and active flag, plus a
// token register toward the next slot. Depends on pva_pkg.
module pva_cell #(
   parameter int LIMIT_W = 5,
   parameter int INDEX   = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [LIMIT_W-1:0]    limit,
   input  pva_pkg::token_type    token_i,
   output pva_pkg::token_type    token_o
);

   localparam logic [LIMIT_W-1:0] MY_INDEX = LIMIT_W'(INDEX);
   localparam logic [LIMIT_W-1:0] MY_NEXT  = LIMIT_W'(INDEX + 1);

   logic [pva_pkg::NOTE_W-1:0] note_ff, note_in;
   logic                       active_ff, active_in;
   pva_pkg::token_type         token_ff, token_in;

   logic is_on, in_range, is_last, claim, clear;

   always_comb begin
      is_on    = token_i.valid && (token_i.kind == pva_pkg::REQ_NOTE_ON);
      in_range = MY_INDEX < limit;
      is_last  = MY_NEXT == limit;
      // idle voice wins if nothing claimed yet; last in-use voice is stolen
      claim    = is_on && in_range && !token_i.found && (!active_ff || is_last);
      clear    = token_i.valid && (token_i.kind == pva_pkg::REQ_NOTE_OFF)
                 && active_ff && (note_ff == token_i.note);

      note_in   = claim ? token_i.note : note_ff;
      active_in = claim ? 1'b1 : (clear ? 1'b0 : active_ff);

      token_in = token_i;
      if (claim) begin
         token_in.found  = 1'b1;
         token_in.chosen = pva_pkg::IDX_W'(INDEX);
      end
      token_in.count = token_i.count + pva_pkg::CNT_W'(active_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         note_ff   <= '0;
         active_ff <= 1'b0;
         token_ff  <= '0;
      end else if (advance) begin
         note_ff   <= note_in;
         active_ff <= active_in;
         token_ff  <= token_in;
      end
   end

   assign token_o = token_ff;

endmodule

### rtl/core/polyphonic_voice_allocator_core.sv
// Polyphonic voice allocator: a chain of voice cells fed by an event token.
// Depends on pva_pkg and pva_cell.
//
// req channel (req_valid/req_ready): one note event per transfer,
//   req_type 1 = note-on, 0 = note-off, with req_note_number.
// rsp channel (rsp_valid/rsp_ready): exactly one result per event:
//   rsp_voice_valid/rsp_voice_index report the voice a note-on got,
//   rsp_active_count the active voices after the event.
// csr port: csr_write_enable with csr_write_data sets voices_in_use (reset 16);
//   values above NUM_VOICES act as NUM_VOICES. Write only while idle.
// Timing: an accepted event visits one voice cell per cycle unless the chain is
//   frozen (see below); rsp_valid rises from the output register after the token
//   leaves the last cell. One event is in flight at a time and req_ready rises
//   together with rsp_valid.
// The result sits in an output register, so a new event is accepted while the
//   previous result still waits; if the next result reaches the end of the
//   chain while the output is held, the chain freezes until the receiver
//   takes the pending transfer.
// Reset (synchronous): all voices idle, no event in flight, no result.
module polyphonic_voice_allocator_core #(
   parameter int NUM_VOICES = pva_pkg::NUM_VOICES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   // event input
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_type,
   input  logic [pva_pkg::NOTE_W-1:0]  req_note_number,
   // result output
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_voice_valid,
   output logic [pva_pkg::IDX_W-1:0]   rsp_voice_index,
   output logic [pva_pkg::CNT_W-1:0]   rsp_active_count,
   // configuration
   input  logic                        csr_write_enable,
   input  logic [pva_pkg::CSR_W-1:0]   csr_write_data
);

   localparam int LIMIT_W = $clog2(NUM_VOICES + 1);
   localparam int CMP_W   = (LIMIT_W > pva_pkg::CSR_W) ? LIMIT_W : pva_pkg::CSR_W;

   logic [pva_pkg::CSR_W-1:0] voices_in_use_ff;
   logic                      busy_ff, busy_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_voice_valid_ff;
   logic [pva_pkg::IDX_W-1:0] rsp_voice_index_ff;
   logic [pva_pkg::CNT_W-1:0] rsp_active_count_ff;

   logic [CMP_W-1:0]   vin_ext;
   logic [LIMIT_W-1:0] limit;
   logic               req_xfer, advance, done;

   pva_pkg::token_type token [0:NUM_VOICES];

   // voices_in_use saturates at the table size
   always_comb begin
      vin_ext = CMP_W'(voices_in_use_ff);
      if (vin_ext > CMP_W'(NUM_VOICES)) begin
         limit = LIMIT_W'(NUM_VOICES);
      end else begin
         limit = LIMIT_W'(vin_ext);
      end
   end

   assign req_ready = !busy_ff;
   assign req_xfer  = req_valid && req_ready;

   // freeze the chain only when a finished token meets a held result
   assign advance = !(token[NUM_VOICES].valid && rsp_valid_ff && !rsp_ready);
   assign done    = token[NUM_VOICES].valid && advance;

   assign token[0].valid  = req_xfer;
   assign token[0].kind   = pva_pkg::req_kind_type'(req_type);
   assign token[0].note   = req_note_number;
   assign token[0].found  = 1'b0;
   assign token[0].chosen = '0;
   assign token[0].count  = '0;

   for (genvar i = 0; i < NUM_VOICES; i++) begin : g_voice
      pva_cell #(
         .LIMIT_W (LIMIT_W),
         .INDEX   (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .limit   (limit),
         .token_i (token[i]),
         .token_o (token[i+1])
      );
   end

   always_comb begin
      busy_in = busy_ff;
      if (req_xfer) begin
         busy_in = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         voices_in_use_ff <= pva_pkg::VOICES_IN_USE_RESET;
         busy_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            voices_in_use_ff <= csr_write_data;
         end
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload; chosen is zero unless a voice was claimed
   always_ff @(posedge clock) begin
      if (done) begin
         rsp_voice_valid_ff  <= token[NUM_VOICES].found;
         rsp_voice_index_ff  <= token[NUM_VOICES].chosen;
         rsp_active_count_ff <= token[NUM_VOICES].count;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_voice_valid  = rsp_voice_valid_ff;
   assign rsp_voice_index  = rsp_voice_index_ff;
   assign rsp_active_count = rsp_active_count_ff;

endmodule

### rtl/core/pva_port_checker.sv
// Port-level assertions for the voice allocator core, bound to the top.
// Depends on pva_pkg and polyphonic_voice_allocator_core.
module pva_port_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_voice_valid,
   input logic [pva_pkg::IDX_W-1:0]   rsp_voice_index
);

   // one event in flight: no back-to-back request transfers
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while an event is in flight");

   // no voice means index zero
   a_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_voice_valid |-> rsp_voice_index == '0)
      else $error("voice index nonzero without a voice");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_voice_index)
                                  && $stable(rsp_voice_valid))
      else $error("result changed while stalled");

endmodule

bind polyphonic_voice_allocator_core pva_port_checker u_pva_port_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_voice_valid (rsp_voice_valid),
   .rsp_voice_index (rsp_voice_index)
);
